>>> design/adx_pkg.sv
// ============================================================================
// adx_pkg
// Shared types, register codes and constants of the ADX ADPCM decoder core.
// ============================================================================
package adx_pkg;

    // Default channel capacity and the fixed width of the channel field that
    // travels between the front and the back (covers up to eight channels).
    localparam int MAX_CHANNELS_DEF = 2;
    localparam int CH_FIELD_W       = 3;

    // Queue depths (powers of two, at least two).
    localparam int JOB_DEPTH_DEF = 2;
    localparam int OUT_DEPTH_DEF = 2;

    // Configuration port.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 14;

    localparam logic [CFG_INDEX_W-1:0] REG_COEFF_ONE     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COEFF_TWO     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_BYTES   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT = 2'd3;

    // Register values after reset.
    localparam logic [13:0]        COEFF_ONE_RST     = 14'd7334;
    localparam logic signed [12:0] COEFF_TWO_RST     = -13'sd3283;
    localparam logic [7:0]         BLOCK_BYTES_RST   = 8'd18;
    localparam logic [1:0]         CHANNEL_COUNT_RST = 2'd2;

    // Stream layout.
    localparam logic [7:0] MIN_BLOCK_BYTES = 8'd3;
    localparam logic [7:0] SCALE_BYTES     = 8'd2;

    // Arithmetic.
    localparam int PRED_SHIFT = 12;
    localparam int SAMPLE_MAX = 32767;
    localparam int SAMPLE_MIN = -32768;

    typedef struct packed {
        logic [13:0]        coeff_one;
        logic signed [12:0] coeff_two;
        logic [7:0]         block_bytes;
        logic [1:0]         channel_count;
    } cfg_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               channel;
        logic [8:0]         index_in_block;
        logic               frame_end;
        logic               run_last;
    } out_item_t;

    // One data byte with everything the back needs to decode it.
    typedef struct packed {
        logic [7:0]            data_byte;
        logic [15:0]           scale;
        logic [CH_FIELD_W-1:0] ch;
        logic [8:0]            idx;
        logic                  frame_end;
        logic                  clear_hist;
    } job_t;

endpackage

>>> design/adx_fifo.sv
// ============================================================================
// adx_fifo
// Small register queue with full/empty flags; the head is shown while not empty.
// ============================================================================
module adx_fifo
    import adx_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = $clog2(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == (PTR_W + 1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

>>> design/adx_front.sv
// ============================================================================
// adx_front
// Stream parser: tracks block position and channel, gathers the scale and
// queues one decode job for every data byte.
// ============================================================================
module adx_front
    import adx_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
    localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  logic     push,
    input  in_item_t item,
    input  logic     job_full,
    output logic     job_push,
    output job_t     job
);

    logic [7:0]      pos_reg,   pos_next;
    logic [CH_W-1:0] ch_reg,    ch_next;
    logic [15:0]     scale_reg, scale_next;
    logic            clr_reg,   clr_next;

    logic            accept;
    logic [7:0]      bb;
    logic [3:0]      cc;
    logic [7:0]      pos_base;
    logic [CH_W-1:0] ch_base;
    logic [15:0]     scale_base;
    logic [7:0]      pos_e;
    logic [CH_W-1:0] ch_e;
    logic            block_done;
    logic            last_block;
    logic [7:0]      data_pos;

    assign accept = push && !job_full;

    always_comb
    begin
        bb = (cfg.block_bytes < MIN_BLOCK_BYTES) ? MIN_BLOCK_BYTES : cfg.block_bytes;

        if (cfg.channel_count == 2'd0)
        begin
            cc = 4'd1;
        end
        else if (int'(cfg.channel_count) > MAX_CHANNELS)
        begin
            cc = 4'(MAX_CHANNELS);
        end
        else
        begin
            cc = {2'b00, cfg.channel_count};
        end

        // A restart clears the stream state before this byte is looked at.
        pos_base   = item.restart ? '0 : pos_reg;
        ch_base    = item.restart ? '0 : ch_reg;
        scale_base = item.restart ? '0 : scale_reg;

        ch_e  = (4'(ch_base) >= cc) ? '0 : ch_base;
        pos_e = (pos_base >= bb) ? '0 : pos_base;

        block_done = ({1'b0, pos_e} + 9'd1) >= {1'b0, bb};
        last_block = (4'(ch_e) + 4'd1) >= cc;
        data_pos   = pos_e - SCALE_BYTES;

        job.data_byte  = item.data_byte;
        job.scale      = scale_base;
        job.ch         = CH_FIELD_W'(ch_e);
        job.idx        = {data_pos, 1'b0};
        job.frame_end  = block_done && last_block;
        job.clear_hist = clr_reg || item.restart;

        job_push = accept && (pos_e >= SCALE_BYTES);

        pos_next   = pos_reg;
        ch_next    = ch_reg;
        scale_next = scale_reg;
        clr_next   = clr_reg;

        if (accept)
        begin
            // The history clear rides on the next data byte that is queued.
            clr_next = (clr_reg || item.restart) && !job_push;
            if (pos_e == 8'd0)
            begin
                scale_next = {item.data_byte, 8'h00};
                pos_next   = 8'd1;
                ch_next    = ch_e;
            end
            else if (pos_e == 8'd1)
            begin
                scale_next = {scale_base[15:8], item.data_byte};
                pos_next   = SCALE_BYTES;
                ch_next    = ch_e;
            end
            else
            begin
                scale_next = scale_base;
                if (block_done)
                begin
                    pos_next = '0;
                    ch_next  = last_block ? '0 : ch_e + 1'b1;
                end
                else
                begin
                    pos_next = pos_e + 8'd1;
                    ch_next  = ch_e;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            ch_reg    <= '0;
            scale_reg <= '0;
            clr_reg   <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            ch_reg    <= ch_next;
            scale_reg <= scale_next;
            clr_reg   <= clr_next;
        end
    end

endmodule

>>> design/adx_back.sv
// ============================================================================
// adx_back
// Sample engine: decodes both nibbles of a queued job, each in turn (predictor
// products, then sum, shift and saturate), and keeps the history.
// ============================================================================
module adx_back
    import adx_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
    localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      job_empty,
    input  job_t      job,
    output logic      job_pop,
    input  logic      out_full,
    output logic      out_push,
    output out_item_t result
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_SUM  = 2'd2;

    logic [1:0]         state_reg;
    logic               nib_reg;
    job_t               job_reg;
    logic signed [31:0] pred_reg;
    logic signed [20:0] dsc_reg;
    logic signed [15:0] h1_reg [MAX_CHANNELS];
    logic signed [15:0] h2_reg [MAX_CHANNELS];

    logic [CH_W-1:0]    ch;
    logic signed [3:0]  d;
    logic signed [30:0] p1;
    logic signed [28:0] p2;
    logic signed [31:0] pred_sum;
    logic signed [20:0] dsc;
    logic signed [19:0] pred_sh;
    logic signed [21:0] total;
    logic signed [15:0] sat;

    always_comb
    begin
        ch       = job_reg.ch[CH_W-1:0];
        d        = nib_reg ? job_reg.data_byte[3:0] : job_reg.data_byte[7:4];
        p1       = $signed({1'b0, cfg.coeff_one}) * h1_reg[ch];
        p2       = cfg.coeff_two * h2_reg[ch];
        pred_sum = 32'(p1) + 32'(p2);
        dsc      = d * $signed({1'b0, job_reg.scale});

        pred_sh  = 20'(pred_reg >>> PRED_SHIFT);
        total    = 22'(dsc_reg) + 22'(pred_sh);
        if (total > SAMPLE_MAX)
        begin
            sat = 16'(SAMPLE_MAX);
        end
        else if (total < SAMPLE_MIN)
        begin
            sat = 16'(SAMPLE_MIN);
        end
        else
        begin
            sat = total[15:0];
        end

        result.sample         = sat;
        result.channel        = ch[0];
        result.index_in_block = job_reg.idx + {8'd0, nib_reg};
        result.frame_end      = nib_reg && job_reg.frame_end;
        result.run_last       = nib_reg;

        out_push = (state_reg == ST_SUM) && !out_full;
        job_pop  = !job_empty &&
                   ((state_reg == ST_IDLE) || ((state_reg == ST_SUM) && nib_reg && !out_full));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            nib_reg   <= 1'b0;
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                h1_reg[i] <= '0;
                h2_reg[i] <= '0;
            end
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (job_pop)
                    begin
                        state_reg <= ST_MUL;
                        nib_reg   <= 1'b0;
                    end
                end
                ST_MUL:
                begin
                    state_reg <= ST_SUM;
                end
                ST_SUM:
                begin
                    if (out_push)
                    begin
                        if (!nib_reg)
                        begin
                            nib_reg   <= 1'b1;
                            state_reg <= ST_MUL;
                        end
                        else if (job_pop)
                        begin
                            nib_reg   <= 1'b0;
                            state_reg <= ST_MUL;
                        end
                        else
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            // A restart ahead of the new job wipes every channel's history,
            // which takes the place of the update from the sample just finished.
            if (job_pop && job.clear_hist)
            begin
                for (int i = 0; i < MAX_CHANNELS; i++)
                begin
                    h1_reg[i] <= '0;
                    h2_reg[i] <= '0;
                end
            end
            else if (out_push)
            begin
                h2_reg[ch] <= h1_reg[ch];
                h1_reg[ch] <= sat;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            job_reg <= job;
        end
        if (state_reg == ST_MUL)
        begin
            pred_reg <= pred_sum;
            dsc_reg  <= dsc;
        end
    end

endmodule

>>> design/adx_adpcm_decoder_core.sv
// ============================================================================
// adx_adpcm_decoder_core
// ADX ADPCM stream decoder: byte stream in, saturated PCM samples out.
// ============================================================================
//
// Channel      Handshake                    Beat
// -----------  ---------------------------  ----------------------------------
// input        push / full                  item: data_byte, restart
// result       empty / pop                  result: sample, channel,
//                                           index_in_block, frame_end, run_last
// config       cfg_valid / cfg_ready        cfg_index, cfg_data
//
// A scale byte is taken in the front and queues no job. In the sample engine
// each nibble of a data byte is worked in turn: the predictor products are
// registered, then the sum, shift and saturation write the sample and the
// history that the second nibble needs.
// Reset loads the register defaults and clears position, channel, scale
// and history. The job queue and the result queue let each side stall on
// its own; full rises only when the job queue is full.
//
// The front parses the stream and hands each data byte, with its scale,
// channel and sample index, to a short job queue. A restart raised on any
// byte is carried forward as a flag on the next queued job, which is the
// point at which the engine clears every channel's history. Results leave
// through a second queue so the engine keeps working while a sample waits.
// ============================================================================
module adx_adpcm_decoder_core
    import adx_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
    parameter int JOB_DEPTH    = JOB_DEPTH_DEF,
    parameter int OUT_DEPTH    = OUT_DEPTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   push,
    input  in_item_t               item,
    output logic                   full,

    input  logic                   pop,
    output out_item_t              result,
    output logic                   empty,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int JOB_W = $bits(job_t);
    localparam int OUT_W = $bits(out_item_t);

    cfg_t             cfg_reg;

    logic             job_push;
    job_t             job_in;
    logic             job_full;
    logic             job_pop;
    logic [JOB_W-1:0] job_rdata;
    logic             job_empty;

    logic             out_push;
    out_item_t        out_in;
    logic             out_full;
    logic [OUT_W-1:0] out_rdata;

    // Registers are always writable; the user must write them only while the block is idle (not enforced here).
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.coeff_one     <= COEFF_ONE_RST;
            cfg_reg.coeff_two     <= COEFF_TWO_RST;
            cfg_reg.block_bytes   <= BLOCK_BYTES_RST;
            cfg_reg.channel_count <= CHANNEL_COUNT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_COEFF_ONE:     cfg_reg.coeff_one     <= cfg_data[13:0];
                REG_COEFF_TWO:     cfg_reg.coeff_two     <= cfg_data[12:0];
                REG_BLOCK_BYTES:   cfg_reg.block_bytes   <= cfg_data[7:0];
                REG_CHANNEL_COUNT: cfg_reg.channel_count <= cfg_data[1:0];
                default:           ;
            endcase
        end
    end

    // Input beats are taken whenever the job queue has room.
    assign full = job_full;

    adx_front #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .push     (push),
        .item     (item),
        .job_full (job_full),
        .job_push (job_push),
        .job      (job_in)
    );

    adx_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (JOB_DEPTH)
    ) u_job_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .wdata (job_in),
        .full  (job_full),
        .pop   (job_pop),
        .rdata (job_rdata),
        .empty (job_empty)
    );

    adx_back #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job_empty (job_empty),
        .job       (job_t'(job_rdata)),
        .job_pop   (job_pop),
        .out_full  (out_full),
        .out_push  (out_push),
        .result    (out_in)
    );

    adx_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (out_in),
        .full  (out_full),
        .pop   (pop),
        .rdata (out_rdata),
        .empty (empty)
    );

    assign result = out_item_t'(out_rdata);

    // The front must never hand a job to a full queue.
    a_job_no_overflow: assert property (
        @(posedge clk) disable iff (!rst_n)
        job_push |-> !job_full
    ) else $error("job queued while the job queue is full");

    // The second sample of a byte always sits at an odd index in its block.
    a_pair_index: assert property (
        @(posedge clk) disable iff (!rst_n)
        !empty |-> (result.run_last == result.index_in_block[0])
    ) else $error("sample index does not match its place within the byte");

    // A frame can only end on the second sample of a byte.
    a_frame_end_last: assert property (
        @(posedge clk) disable iff (!rst_n)
        (!empty && result.frame_end) |-> result.run_last
    ) else $error("frame end flagged on the first sample of a byte");

endmodule

>>> tb/adx_sample_checker.sv
// ============================================================================
// adx_sample_checker
// Watches the byte, sample and register channels of the ADX decoder core,
// predicts every decoded sample and compares it with what leaves the core.
// ============================================================================
`timescale 1ns / 100ps

module adx_sample_checker
    import adx_pkg::*;
#(
    parameter int CHANNELS = MAX_CHANNELS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic                   full,
    input  in_item_t               item,
    input  logic                   pop,
    input  logic                   empty,
    input  out_item_t              result,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     failures,
    output int                     outstanding,
    output int                     compared
);

    logic [13:0]        cfg_coeff1;
    logic signed [12:0] cfg_coeff2;
    logic [7:0]         cfg_block_len;
    logic [1:0]         cfg_chans;

    int unsigned        pos_in_block;
    int unsigned        chan_now;
    logic [15:0]        cur_scale;
    logic signed [15:0] prev1 [CHANNELS];
    logic signed [15:0] prev2 [CHANNELS];

    out_item_t          pending_samples [$];
    int                 fail_count  = 0;
    int                 check_count = 0;
    int                 held_count  = 0;

    assign failures    = fail_count;
    assign compared    = check_count;
    assign outstanding = held_count;

    function automatic void report_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t ns: %s", $time, msg);
    endfunction

    function automatic void restart_stream();
        pos_in_block = 0;
        chan_now     = 0;
        cur_scale    = '0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            prev1[c] = '0;
            prev2[c] = '0;
        end
    endfunction

    // One nibble: scaled delta plus the floored prediction, clipped to 16 bits.
    function automatic logic signed [15:0] adpcm_nibble(input int unsigned ch,
                                                        input logic [3:0] nib);
        longint             pred;
        longint             acc;
        logic signed [15:0] s;
        pred = longint'(cfg_coeff1) * longint'(prev1[ch])
             + longint'(cfg_coeff2) * longint'(prev2[ch]);
        acc  = longint'($signed(nib)) * longint'(cur_scale) + (pred >>> PRED_SHIFT);
        if (acc > SAMPLE_MAX)
            acc = SAMPLE_MAX;
        if (acc < SAMPLE_MIN)
            acc = SAMPLE_MIN;
        s         = acc[15:0];
        prev2[ch] = prev1[ch];
        prev1[ch] = s;
        return s;
    endfunction

    function automatic void decode_byte(input in_item_t b);
        int unsigned blen;
        int unsigned nch;
        int unsigned idx;
        bit          block_done;
        bit          last_chan;
        out_item_t   hi;
        out_item_t   lo;
        blen = (cfg_block_len < MIN_BLOCK_BYTES) ? MIN_BLOCK_BYTES : cfg_block_len;
        nch  = (cfg_chans == 2'd0) ? 1 : cfg_chans;
        if (nch > CHANNELS)
            nch = CHANNELS;
        if (b.restart)
            restart_stream();
        if (chan_now >= nch)
            chan_now = 0;
        if (pos_in_block >= blen)
            pos_in_block = 0;
        block_done = (pos_in_block + 1 >= blen);
        last_chan  = (chan_now + 1 >= nch);

        if (pos_in_block < SCALE_BYTES)
        begin
            if (pos_in_block == 0)
                cur_scale = {b.data_byte, 8'h00};
            else
                cur_scale[7:0] = b.data_byte;
            pos_in_block++;
        end
        else
        begin
            idx = (pos_in_block - SCALE_BYTES) * 2;
            hi.sample         = adpcm_nibble(chan_now, b.data_byte[7:4]);
            hi.channel        = chan_now[0];
            hi.index_in_block = idx[8:0];
            hi.frame_end      = 1'b0;
            hi.run_last       = 1'b0;
            lo.sample         = adpcm_nibble(chan_now, b.data_byte[3:0]);
            lo.channel        = chan_now[0];
            lo.index_in_block = 9'(idx + 1);
            lo.frame_end      = block_done && last_chan;
            lo.run_last       = 1'b1;
            pending_samples.push_back(hi);
            pending_samples.push_back(lo);
            if (block_done)
            begin
                pos_in_block = 0;
                chan_now     = last_chan ? 0 : chan_now + 1;
            end
            else
                pos_in_block++;
        end
    endfunction

    function automatic void check_sample();
        out_item_t want;
        if (pending_samples.size() == 0)
            report_failure($sformatf("sample %0d ch %0d idx %0d with none outstanding",
                                     result.sample, result.channel, result.index_in_block));
        else
        begin
            want = pending_samples.pop_front();
            check_count++;
            if (result.sample !== want.sample || result.channel !== want.channel
                || result.index_in_block !== want.index_in_block
                || result.frame_end !== want.frame_end || result.run_last !== want.run_last)
                report_failure($sformatf(
                    "expected %0d ch %0d idx %0d fe %0b last %0b, got %0d ch %0d idx %0d fe %0b last %0b",
                    want.sample, want.channel, want.index_in_block, want.frame_end,
                    want.run_last, result.sample, result.channel, result.index_in_block,
                    result.frame_end, result.run_last));
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_coeff1    = COEFF_ONE_RST;
            cfg_coeff2    = COEFF_TWO_RST;
            cfg_block_len = BLOCK_BYTES_RST;
            cfg_chans     = CHANNEL_COUNT_RST;
            restart_stream();
            pending_samples.delete();
            held_count = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_COEFF_ONE:     cfg_coeff1    = cfg_data[13:0];
                    REG_COEFF_TWO:     cfg_coeff2    = cfg_data[12:0];
                    REG_BLOCK_BYTES:   cfg_block_len = cfg_data[7:0];
                    REG_CHANNEL_COUNT: cfg_chans     = cfg_data[1:0];
                    default: ;
                endcase
            end
            if (pop && !empty)
                check_sample();
            if (push && !full)
                decode_byte(item);
            held_count = pending_samples.size();
        end
    end

endmodule

>>> tb/tb_adx_adpcm_decoder_core.sv
// ============================================================================
// tb_adx_adpcm_decoder_core
// Drives ADX frame byte streams into the decoder core under a series of
// register settings, with random gaps on both queues and one long output
// stall, and lets the sample checker judge every decoded sample.
// ============================================================================
`timescale 1ns / 100ps

module tb_adx_adpcm_decoder_core
    import adx_pkg::*;
;

    // Cycles with no beat on any channel before the run is declared hung.
    // The slowest legal quiet stretch is the long output stall below plus
    // a few sender and receiver gaps, so this leaves a wide margin.
    localparam int IDLE_LIMIT    = 2000;
    // Cycles to let pass once nothing is outstanding. A scale byte gives no
    // sample, so the core can still be busy with one when the queue drains.
    localparam int SETTLE_CYCLES = 12;
    // The long receiver hold-off starts once this many bytes are in, and
    // lasts long enough for both internal queues to fill and full to rise.
    localparam int HOLD_AT       = 300;
    localparam int HOLD_CYCLES   = 200;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   push;
    in_item_t               item;
    logic                   full;
    logic                   pop;
    out_item_t              result;
    logic                   empty;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int failures;
    int outstanding;
    int compared;

    int bytes_sent;
    int settings_used;
    int quiet_cycles = 0;
    bit tx_steady;
    bit rx_steady;
    bit hold_request;

    // Directed opening on the reset registers (18-byte blocks, two channels):
    // bit 8 is the restart flag, bits 7:0 the stream byte. It walks through the
    // largest positive scale, the all-ones scale and a zero scale (where only
    // the predictor moves the sample), with both nibble extremes (+7 and -8)
    // in each position and restarts landing mid-block.
    logic [8:0] warmup_bytes [0:19] = '{
        9'h17F, 9'h0FF, 9'h077, 9'h088, 9'h07F, 9'h0F8, 9'h000,
        9'h1FF, 9'h0FF, 9'h078, 9'h087, 9'h0FF,
        9'h100, 9'h000, 9'h000, 9'h011,
        9'h100, 9'h001, 9'h07F, 9'h080
    };

    // Minimum-length blocks with two channels: every third byte closes a block
    // and every sixth one closes a frame, so frame_end shows up right away.
    logic [8:0] frame_bytes [0:5] = '{
        9'h112, 9'h034, 9'h09C, 9'h000, 9'h010, 9'h0E3
    };

    always #5 clk = ~clk;

    adx_adpcm_decoder_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .pop       (pop),
        .result    (result),
        .empty     (empty),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // The checker sees exactly the beats the core sees and keeps its own
    // decoder state; all verdict input comes back through these three counts.
    adx_sample_checker u_sample_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .item        (item),
        .pop         (pop),
        .empty       (empty),
        .result      (result),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .failures    (failures),
        .outstanding (outstanding),
        .compared    (compared)
    );

    // Gap lengths: mostly none, often a cycle or three, now and then a long
    // pause. A steady stretch turns gaps off entirely.
    function automatic int pick_gap(input bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Random stream bytes: half fully random, some small values (which as
    // scale bytes keep the samples out of saturation) and some extremes.
    function automatic logic [7:0] random_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return 8'($urandom_range(0, 255));
        if (r < 8)
            return 8'($urandom_range(0, 31));
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h7F;
            3:       return 8'h80;
            4:       return 8'h08;
            default: return 8'h77;
        endcase
    endfunction

    // Offers one byte beat and returns at the falling edge after it was taken.
    // Push is only lowered for a gap, so back-to-back beats keep it high.
    task automatic push_byte(input in_item_t b, input int gap);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push <= 1'b1;
        item <= b;
        forever
        begin
            @(posedge clk);
            if (!full)
                break;
        end
        bytes_sent++;
        @(negedge clk);
    endtask

    // Waits for every predicted sample to come out, then a little longer.
    task automatic settle_idle();
        push <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Writes all four registers in one burst with valid held high. The spare
    // upper bits of the last three data words are random; the core must ignore them.
    task automatic write_settings(input logic [13:0] c1, input logic signed [12:0] c2,
                                  input logic [7:0] bb, input logic [1:0] cc);
        logic [CFG_DATA_W-1:0]  words [4];
        logic [CFG_INDEX_W-1:0] regs  [4];
        words[0] = c1;
        words[1] = {1'($urandom_range(0, 1)), c2};
        words[2] = {6'($urandom_range(0, 63)), bb};
        words[3] = {12'($urandom_range(0, 4095)), cc};
        regs[0]  = REG_COEFF_ONE;
        regs[1]  = REG_COEFF_TWO;
        regs[2]  = REG_BLOCK_BYTES;
        regs[3]  = REG_CHANNEL_COUNT;
        for (int i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= words[i];
            forever
            begin
                @(posedge clk);
                if (cfg_ready)
                    break;
            end
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // One phase of random traffic under a fresh register setting. The stream
    // is left where the last phase stopped, so a shorter block length or a
    // smaller channel count also exercises the wrap-back of position and
    // channel. Restarts are rare so that most blocks run to completion.
    task automatic run_random_phase(input logic [13:0] c1, input logic signed [12:0] c2,
                                    input logic [7:0] bb, input logic [1:0] cc,
                                    input int count);
        in_item_t b;
        settle_idle();
        write_settings(c1, c2, bb, cc);
        tx_steady = ($urandom_range(0, 3) == 0);
        rx_steady = ($urandom_range(0, 3) == 0);
        repeat (count)
        begin
            b.data_byte = random_byte();
            b.restart   = ($urandom_range(0, 59) == 0);
            push_byte(b, pick_gap(tx_steady));
            if (bytes_sent == HOLD_AT)
                hold_request = 1'b1;
        end
    endtask

    // Sample receiver. It pops with random stalls, and once asked it refuses
    // samples for a long stretch while the sender keeps offering bytes, so the
    // result queue, then the job queue, fill up and full holds the input off.
    initial
    begin : receiver
        int stall;
        stall = 0;
        pop   = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_request = 1'b0;
            end
            else if (stall > 0)
            begin
                pop <= 1'b0;
                stall--;
            end
            else
            begin
                pop <= 1'b1;
                stall = pick_gap(rx_steady);
            end
        end
    end

    // Hang detection: any beat on any channel restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == IDLE_LIMIT)
        begin
            $display("adx_adpcm_decoder_core test failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        push          = 1'b0;
        item          = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        rst_n         = 1'b0;
        tx_steady     = 1'b0;
        rx_steady     = 1'b0;
        hold_request  = 1'b0;
        bytes_sent    = 0;
        settings_used = 1;

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, first on the register values that reset leaves.
        foreach (warmup_bytes[i])
            push_byte(in_item_t'({warmup_bytes[i][7:0], warmup_bytes[i][8]}), pick_gap(1'b0));
        settle_idle();
        write_settings(14'd7334, -13'sd3283, 8'd3, 2'd2);
        foreach (frame_bytes[i])
            push_byte(in_item_t'({frame_bytes[i][7:0], frame_bytes[i][8]}), pick_gap(1'b0));

        // Random part. Settings run from zero coefficients to the largest
        // values the register widths hold, block lengths from the shortest
        // (including the values below three that act as three) to 255, and
        // channel counts 0 to 3, where 0 acts as one and 3 as two.
        run_random_phase(14'd0, 13'sd0, 8'd3, 2'd1, 50);
        run_random_phase(14'd8192, 13'sh1000, 8'd40, 2'd2, 90);
        run_random_phase(14'h3FFF, 13'sd4095, 8'd0, 2'd0, 60);
        run_random_phase(14'd7334, -13'sd3283, 8'd255, 2'd3, 160);
        run_random_phase(14'd5000, -13'sd2000, 8'd2, 2'd2, 40);
        repeat (2)
            run_random_phase(14'($urandom_range(0, 8192)), -13'($urandom_range(0, 4096)),
                             8'($urandom_range(3, 24)), 2'($urandom_range(1, 2)), 75);

        settle_idle();

        $display("Summary: %0d stream bytes under %0d register settings, %0d samples compared.",
                 bytes_sent, settings_used, compared);
        $display("Blocks ran from 3 to 255 bytes over one and two channels, with a long output stall.");
        if (failures == 0 && outstanding == 0)
            $display("adx_adpcm_decoder_core test passed");
        else
            $display("adx_adpcm_decoder_core test failed");
        $finish;
    end

endmodule
